// File: rtl/skdc_pkg.sv
// Shared types, constants and table builders for the soft-knee compressor.
// No dependencies; every other file imports this package.
package skdc_pkg;

    // Status of a multi-cycle helper unit.
    typedef struct packed {
        logic busy;
    } unit_stat_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_KNEE      = 3'd1;
    localparam logic [2:0] CFG_KNEE_RCP  = 3'd2;
    localparam logic [2:0] CFG_SLOPE     = 3'd3;
    localparam logic [2:0] CFG_ATTACK    = 3'd4;
    localparam logic [2:0] CFG_RELEASE   = 3'd5;
    localparam logic [2:0] CFG_MAKEUP    = 3'd6;

    // Register reset values.
    localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
    localparam logic [12:0]        KNEE_RST      = 13'd0;
    localparam logic [15:0]        KNEE_RCP_RST  = 16'd0;
    localparam logic signed [15:0] SLOPE_RST     = -16'sd16384;
    localparam logic [15:0]        ATTACK_RST    = 16'd64000;
    localparam logic [15:0]        RELEASE_RST   = 16'd65400;
    localparam logic [15:0]        MAKEUP_RST    = 16'd4096;

    // Arithmetic constants.
    localparam logic signed [17:0] DB_FLOOR        = -18'sd30720;  // -120 dB, Q7.8
    localparam logic [21:0]        DB_PER_LOG2     = 22'd394566;   // 20*log10(2), Q16
    localparam logic [21:0]        LOG2_PER_DB     = 22'd10885;    // log2(10)/20, Q16
    localparam logic [12:0]        HARD_KNEE_LIMIT = 13'd26;       // 0.1 dB, Q7.8
    localparam int                 MUL_BW          = 22;           // multiplier bits

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        longint unsigned x;
        res = 0;
        bt  = 64'd1 << 62;
        x   = v;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^l), Q0.16, truncated.
    function automatic logic [15:0] log_entry(input int l, input int i);
        longint unsigned x;
        longint unsigned lg;
        x  = 64'((64'd1 << l) + 64'(i)) << (30 - l);
        lg = 0;
        for (int j = 0; j < 16; j++) begin
            x  = (x * x) >> 30;
            lg = lg << 1;
            if (x >= (64'd1 << 31)) begin
                lg = lg | 64'd1;
                x  = x >> 1;
            end
        end
        return 16'(lg);
    endfunction

    // 2^(-i/2^l), Q1.30.
    function automatic logic [30:0] pow_entry(input int l, input int i);
        longint unsigned roots [0:12];
        longint unsigned p;
        for (int m = 0; m <= 12; m++) roots[m] = 0;
        roots[0] = 64'd1 << 30;
        roots[1] = isqrt64(64'd1 << 59);
        for (int m = 2; m <= l; m++) roots[m] = isqrt64(roots[m - 1] << 30);
        p = 64'd1 << 30;
        for (int j = 0; j < l; j++) begin
            if (((i >> j) & 1) != 0) p = (p * roots[l - j]) >> 30;
        end
        return 31'(p);
    endfunction

endpackage

// File: rtl/soft_knee_dynamic_compressor_unit.sv
// Top level of the feed-forward soft-knee stereo compressor.
// Uses skdc_pkg, skdc_serial_mul and skdc_lead_norm.
//
// One word on the input channel is a stereo pair (left_in, right_in); one word
// on the output channel is the gained pair plus gain_db, the envelope after
// that pair. The block works on one pair at a time: peak detect, a leading-one
// search of one bit per cycle, a log table read, then up to ten products on
// one shared bit-serial multiplier that retires one multiplier bit per cycle
// (level, knee square, knee scale, slope, two envelope terms, dB to log2,
// makeup, left, right). The time from acceptance to a valid output word is
// set by the leading-one position of the peak, by the bit length of each
// product's multiplier operand (register values, gain) and by how long the
// output register stays full. A finished word sits in the output register
// while the next pair is accepted. Config writes are taken at any time
// (cfg_ready is always high) but must only happen while no pair is in
// flight. Index 7 is ignored.
module soft_knee_dynamic_compressor_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic signed [15:0]            gain_db,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import skdc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int LB    = LOG_TABLE_BITS;
    localparam int TSIZE = 1 << LB;
    localparam int SHW   = $clog2(SB);
    localparam int RELW  = SHW + 16;
    localparam int AW    = (SB > 31) ? SB : 31;
    localparam int PW    = AW + MUL_BW;
    localparam logic [SB-1:0]   PEAK_FLOOR = SB'((64'd1 << (SB - 1)) / 64'd1000000);
    localparam logic [PW-17:0]  SAT_POS    = (PW-16)'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [PW-17:0]  SAT_NEG    = (PW-16)'(64'd1 << (SB - 1));

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PEAK = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_LOGT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_GAIN = 4'd5;
    localparam logic [3:0] S_ENV  = 4'd6;
    localparam logic [3:0] S_POW  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // Which product the multiplier is working on.
    localparam logic [3:0] OP_LVL   = 4'd0;
    localparam logic [3:0] OP_KSQ   = 4'd1;
    localparam logic [3:0] OP_KREC  = 4'd2;
    localparam logic [3:0] OP_SLOPE = 4'd3;
    localparam logic [3:0] OP_ENV_A = 4'd4;
    localparam logic [3:0] OP_ENV_B = 4'd5;
    localparam logic [3:0] OP_N     = 4'd6;
    localparam logic [3:0] OP_G     = 4'd7;
    localparam logic [3:0] OP_L     = 4'd8;
    localparam logic [3:0] OP_R     = 4'd9;

    // Constant tables.
    logic [15:0] log_tab [TSIZE];
    logic [30:0] pow_tab [TSIZE];
    for (genvar gi = 0; gi < TSIZE; gi++)
    begin : g_tab
        assign log_tab[gi] = log_entry(LB, gi);
        assign pow_tab[gi] = pow_entry(LB, gi);
    end

    // Config registers.
    logic signed [14:0] thr_reg;
    logic [12:0]        knee_reg;
    logic [15:0]        krcp_reg;
    logic signed [15:0] slope_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic [15:0]        makeup_reg;

    // Control and datapath registers.
    logic [3:0]            state_reg, state_next;
    logic [3:0]            op_reg, op_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [15:0]    envelope_reg, envelope_next;
    logic signed [SB-1:0]  l_reg, l_next, r_reg, r_next;
    logic signed [17:0]    lvl_reg, lvl_next;
    logic [16:0]           tmag_reg, tmag_next;
    logic [15:0]           c_reg, c_next;
    logic [20:0]           n_reg, n_next;
    logic [20:0]           g_reg, g_next;
    logic [SB-1:0]         lres_reg, lres_next, rres_reg, rres_next;
    logic [SB-1:0]         lout_reg, lout_next, rout_reg, rout_next;
    logic signed [15:0]    gout_reg, gout_next;

    // Helper units.
    logic                  mul_start;
    logic [AW-1:0]         mul_a;
    logic [MUL_BW-1:0]     mul_b;
    logic [PW-1:0]         mul_init;
    logic [PW-1:0]         prod;
    unit_stat_t            mul_stat;
    logic                  norm_start;
    unit_stat_t            norm_stat;
    logic [SHW-1:0]        norm_sh;
    logic [LB-1:0]         norm_idx;
    logic [SB-1:0]         abs_l, abs_r, peak_abs;

    skdc_serial_mul #(.AW(AW), .BW(MUL_BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .init  (mul_init),
        .stat  (mul_stat),
        .prod  (prod)
    );

    skdc_lead_norm #(.SB(SB), .LB(LB), .SHW(SHW)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .peak  (peak_abs),
        .stat  (norm_stat),
        .shift (norm_sh),
        .index (norm_idx)
    );

    // Saturating sign restore of a product magnitude.
    function automatic logic [SB-1:0] sat_apply(input logic neg, input logic [PW-17:0] m);
        logic [SB-1:0] t;
        t = SB'(m);
        if (!neg)
        begin
            return (m > SAT_POS) ? SB'(SAT_POS) : t;
        end
        return (m > SAT_NEG) ? SB'(SAT_NEG) : SB'(-t);
    endfunction

    // Peak magnitude of the held pair.
    assign abs_l    = l_reg[SB-1] ? SB'(-l_reg) : SB'(l_reg);
    assign abs_r    = r_reg[SB-1] ? SB'(-r_reg) : SB'(r_reg);
    assign peak_abs = (abs_l > abs_r) ? abs_l : abs_r;

    // Gain computer terms, doubled to keep half a knee exact.
    logic signed [19:0] lvl_x, thr_x, knee_x, in2, lo2, hi2, ex, k2;
    assign lvl_x  = 20'(lvl_reg);
    assign thr_x  = 20'(thr_reg);
    assign knee_x = 20'(signed'({1'b0, knee_reg}));
    assign in2    = lvl_x <<< 1;
    assign lo2    = (thr_x <<< 1) - knee_x;
    assign hi2    = (thr_x <<< 1) + knee_x;
    assign ex     = lvl_x - thr_x;
    assign k2     = in2 - lo2;

    logic [15:0]    slope_mag;
    logic [16:0]    env_mag;
    logic [RELW-1:0] rel;
    logic [PW-16:0] q_full;
    logic [LB-1:0]  pow_idx;
    logic [4:0]     pow_sh;
    logic [30:0]    lin;
    assign slope_mag = 16'(-slope_reg);
    assign env_mag   = 17'(-(17'(envelope_reg)));
    assign rel       = {norm_sh, 16'd0} - RELW'(log_tab[norm_idx]);
    assign q_full    = prod[PW-1:15];
    assign pow_idx   = n_reg[15 -: LB];
    assign pow_sh    = n_reg[20:16];
    assign lin       = (pow_sh == 5'd31) ? 31'd0 : (pow_tab[pow_idx] >> pow_sh);

    // Sequencer.
    logic            go_slope;
    logic [21:0]     slope_in;
    logic [16:0]     emag_new;
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        envelope_next  = envelope_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        lvl_next       = lvl_reg;
        tmag_next      = tmag_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        g_next         = g_reg;
        lres_next      = lres_reg;
        rres_next      = rres_reg;
        lout_next      = lout_reg;
        rout_next      = rout_reg;
        gout_next      = gout_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        mul_init       = '0;
        norm_start     = 1'b0;
        go_slope       = 1'b0;
        slope_in       = '0;
        emag_new       = prod[16 +: 17];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    l_next     = left_in;
                    r_next     = right_in;
                    state_next = S_PEAK;
                end
            end
            S_PEAK:
            begin
                if (peak_abs <= PEAK_FLOOR)
                begin
                    lvl_next   = DB_FLOOR;
                    state_next = S_GAIN;
                end
                else
                begin
                    norm_start = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (!norm_stat.busy)
                begin
                    state_next = S_LOGT;
                end
            end
            S_LOGT:
            begin
                mul_start  = 1'b1;
                mul_a      = AW'(rel);
                mul_b      = DB_PER_LOG2;
                op_next    = OP_LVL;
                state_next = S_MUL;
            end
            S_GAIN:
            begin
                if (in2 < lo2)
                begin
                    tmag_next  = '0;
                    state_next = S_ENV;
                end
                else if (in2 > hi2 || knee_reg < HARD_KNEE_LIMIT)
                begin
                    if (ex <= 20'sd0)
                    begin
                        tmag_next  = '0;
                        state_next = S_ENV;
                    end
                    else
                    begin
                        go_slope = 1'b1;
                        slope_in = 22'(ex);
                    end
                end
                else
                begin
                    // knee region: square the distance into the knee
                    mul_start  = 1'b1;
                    mul_a      = AW'(k2);
                    mul_b      = MUL_BW'(k2);
                    op_next    = OP_KSQ;
                    state_next = S_MUL;
                end
            end
            S_ENV:
            begin
                // attack when the target lies below the envelope
                c_next     = (tmag_reg > env_mag) ? attack_reg : release_reg;
                mul_start  = 1'b1;
                mul_a      = AW'(env_mag);
                mul_b      = MUL_BW'((tmag_reg > env_mag) ? attack_reg : release_reg);
                op_next    = OP_ENV_A;
                state_next = S_MUL;
            end
            S_POW:
            begin
                mul_start  = 1'b1;
                mul_a      = AW'(lin);
                mul_b      = MUL_BW'(makeup_reg);
                op_next    = OP_G;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (!mul_stat.busy)
                begin
                    case (op_reg)
                        OP_LVL:
                        begin
                            lvl_next   = -(18'(prod[24 +: 16]));
                            state_next = S_GAIN;
                        end
                        OP_KSQ:
                        begin
                            mul_start = 1'b1;
                            mul_a     = AW'(prod[27:0]);
                            mul_b     = MUL_BW'(krcp_reg);
                            op_next   = OP_KREC;
                        end
                        OP_KREC:
                        begin
                            go_slope = 1'b1;
                            slope_in = prod[22 +: 22];
                        end
                        OP_SLOPE:
                        begin
                            tmag_next  = (q_full > (PW-15)'(32768)) ? 17'd32768
                                                                    : 17'(q_full);
                            state_next = S_ENV;
                        end
                        OP_ENV_A:
                        begin
                            mul_start = 1'b1;
                            mul_a     = AW'(tmag_reg);
                            mul_b     = MUL_BW'(17'd65536 - 17'(c_reg));
                            mul_init  = prod;
                            op_next   = OP_ENV_B;
                        end
                        OP_ENV_B:
                        begin
                            envelope_next = 16'(-(17'(emag_new)));
                            mul_start     = 1'b1;
                            mul_a         = AW'(emag_new);
                            mul_b         = LOG2_PER_DB;
                            op_next       = OP_N;
                        end
                        OP_N:
                        begin
                            n_next     = prod[8 +: 21];
                            state_next = S_POW;
                        end
                        OP_G:
                        begin
                            g_next    = prod[26 +: 21];
                            mul_start = 1'b1;
                            mul_a     = AW'(abs_l);
                            mul_b     = MUL_BW'(prod[26 +: 21]);
                            op_next   = OP_L;
                        end
                        OP_L:
                        begin
                            lres_next = sat_apply(l_reg[SB-1], prod[PW-1:16]);
                            mul_start = 1'b1;
                            mul_a     = AW'(abs_r);
                            mul_b     = MUL_BW'(g_reg);
                            op_next   = OP_R;
                        end
                        OP_R:
                        begin
                            rres_next  = sat_apply(r_reg[SB-1], prod[PW-1:16]);
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    lout_next      = lres_reg;
                    rout_next      = rres_reg;
                    gout_next      = envelope_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // slope stage, shared by the straight and knee paths
        if (go_slope)
        begin
            if (!slope_reg[15])
            begin
                tmag_next  = '0;    // non-negative slope never boosts
                state_next = S_ENV;
            end
            else
            begin
                mul_start  = 1'b1;
                mul_a      = AW'(slope_in);
                mul_b      = MUL_BW'(slope_mag);
                op_next    = OP_SLOPE;
                state_next = S_MUL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_LVL;
            out_valid_reg <= 1'b0;
            envelope_reg  <= '0;
            thr_reg       <= THRESHOLD_RST;
            knee_reg      <= KNEE_RST;
            krcp_reg      <= KNEE_RCP_RST;
            slope_reg     <= SLOPE_RST;
            attack_reg    <= ATTACK_RST;
            release_reg   <= RELEASE_RST;
            makeup_reg    <= MAKEUP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
            envelope_reg  <= envelope_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg     <= cfg_data[14:0];
                    CFG_KNEE:      knee_reg    <= cfg_data[12:0];
                    CFG_KNEE_RCP:  krcp_reg    <= cfg_data;
                    CFG_SLOPE:     slope_reg   <= cfg_data;
                    CFG_ATTACK:    attack_reg  <= cfg_data;
                    CFG_RELEASE:   release_reg <= cfg_data;
                    CFG_MAKEUP:    makeup_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        lvl_reg  <= lvl_next;
        tmag_reg <= tmag_next;
        c_reg    <= c_next;
        n_reg    <= n_next;
        g_reg    <= g_next;
        lres_reg <= lres_next;
        rres_reg <= rres_next;
        lout_reg <= lout_next;
        rout_reg <= rout_next;
        gout_reg <= gout_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = lout_reg;
    assign right_out = rout_reg;
    assign gain_db   = gout_reg;

    // The envelope only ever holds a reduction.
    a_env_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        envelope_reg[15] || envelope_reg == 16'sd0)
        else $error("envelope went positive");

    // No product is launched over one still in progress.
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    // Normalizer is only started from the peak stage.
    a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
        norm_start |-> state_reg == S_PEAK && !mul_stat.busy)
        else $error("normalizer started out of sequence");

    // An accepted pair always leaves idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_PEAK)
        else $error("accepted pair not started");

    // A reported gain never boosts.
    a_gain_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain_db[15] || gain_db == 16'sd0)
        else $error("gain_db positive");

endmodule

// File: rtl/skdc_serial_mul.sv
// Bit-serial shift-add multiplier: prod = init + a * b, one multiplier bit
// per cycle, finishing early once the remaining bits are zero. Uses skdc_pkg.
module skdc_serial_mul #(
    parameter int AW = 32,
    parameter int BW = 22
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    input  logic [AW+BW-1:0]     init,
    output skdc_pkg::unit_stat_t stat,
    output logic [AW+BW-1:0]     prod
);
    import skdc_pkg::*;

    localparam int PW = AW + BW;

    logic [PW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [PW-1:0] acc_reg, acc_next;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            a_next   = PW'(a);
            b_next   = b;
            acc_next = init;
        end
        else if (b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = a_reg << 1;
            b_next = b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = (b_reg != '0);
    assign prod      = acc_reg;

endmodule

// File: rtl/skdc_lead_norm.sv
// Serial leading-one normalizer: shifts the peak left one bit per cycle
// until its top bit is set, counting shifts. Uses skdc_pkg.
module skdc_lead_norm #(
    parameter int SB  = 24,
    parameter int LB  = 8,
    parameter int SHW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SB-1:0]        peak,
    output skdc_pkg::unit_stat_t stat,
    output logic [SHW-1:0]       shift,
    output logic [LB-1:0]        index
);
    import skdc_pkg::*;

    logic [SB-1:0]  norm_reg, norm_next;
    logic [SHW-1:0] sh_reg, sh_next;
    logic           busy;

    assign busy = (norm_reg != '0) && !norm_reg[SB-1];

    always_comb
    begin
        norm_next = norm_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            norm_next = peak;
            sh_next   = '0;
        end
        else if (busy)
        begin
            norm_next = norm_reg << 1;
            sh_next   = sh_reg + SHW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= '0;
            sh_reg   <= '0;
        end
        else
        begin
            norm_reg <= norm_next;
            sh_reg   <= sh_next;
        end
    end

    assign stat.busy = busy;
    assign shift     = sh_reg;
    assign index     = norm_reg[SB-2 -: LB];   // mantissa bits below the leading one

endmodule
